// ----- rtl/rbst_pkg.sv -----
package rbst_pkg;

    // per-beat sideband that rides next to the divider pipeline
    typedef struct packed {
        logic [2:0] par;        // axis direction is zero
        logic       excl;       // a parallel axis puts the origin outside its slab
        logic [2:0] neg_enter;  // entry quotient takes a minus sign
        logic [2:0] neg_exit;   // exit quotient takes a minus sign
    } rbst_side_t;

    localparam int NUM_AXES = 3;

endpackage

// ----- rtl/rbst_prep.sv -----
module rbst_prep #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  logic                                                     en,
    input  logic                                                     valid_in,
    input  logic [rbst_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]           lo,
    input  logic [rbst_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]           hi,
    input  logic [rbst_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]           org,
    input  logic [rbst_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]           dir,
    output logic                                                     valid_reg,
    output logic [rbst_pkg::NUM_AXES-1:0][COORD_WIDTH+FRAC_BITS:0]   num_enter_reg,
    output logic [rbst_pkg::NUM_AXES-1:0][COORD_WIDTH+FRAC_BITS:0]   num_exit_reg,
    output logic [rbst_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]           den_reg,
    output rbst_pkg::rbst_side_t                                     side_reg
);
    import rbst_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic [NUM_AXES-1:0][CW+FRAC_BITS:0] num_enter_next;
    logic [NUM_AXES-1:0][CW+FRAC_BITS:0] num_exit_next;
    logic [NUM_AXES-1:0][CW-1:0]         den_next;
    rbst_side_t                          side_next;

    always_comb
    begin
        logic signed [CW:0] de;
        logic signed [CW:0] dx;
        logic [CW:0]        me;
        logic [CW:0]        mx;
        logic               dneg;
        logic               outside;
        side_next = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            dneg = dir[a][CW-1];
            // entry end is the lower bound for a positive direction
            if (dneg)
            begin
                de = $signed({hi[a][CW-1], hi[a]}) - $signed({org[a][CW-1], org[a]});
                dx = $signed({lo[a][CW-1], lo[a]}) - $signed({org[a][CW-1], org[a]});
            end
            else
            begin
                de = $signed({lo[a][CW-1], lo[a]}) - $signed({org[a][CW-1], org[a]});
                dx = $signed({hi[a][CW-1], hi[a]}) - $signed({org[a][CW-1], org[a]});
            end
            me = de[CW] ? $unsigned(-de) : $unsigned(de);
            mx = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
            num_enter_next[a] = {me, {FRAC_BITS{1'b0}}};
            num_exit_next[a]  = {mx, {FRAC_BITS{1'b0}}};
            den_next[a] = dneg ? CW'(-dir[a]) : dir[a];
            side_next.neg_enter[a] = de[CW] ^ dneg;
            side_next.neg_exit[a]  = dx[CW] ^ dneg;
            side_next.par[a] = (dir[a] == '0);
            outside = ($signed(org[a]) < $signed(lo[a])) || ($signed(org[a]) > $signed(hi[a]));
            if (side_next.par[a] && outside)
            begin
                side_next.excl = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_enter_reg <= num_enter_next;
            num_exit_reg  <= num_exit_next;
            den_reg       <= den_next;
            side_reg      <= side_next;
        end
    end

endmodule

// ----- rtl/rbst_div.sv -----
module rbst_div #(
    parameter int CW = 32,
    parameter int NW = 49
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [CW-1:0] den,
    output logic [NW-1:0] quo
);

    // restoring division, one quotient bit per stage; numerator bits shift
    // out at the top while quotient bits shift in at the bottom
    logic [NW-1:0] nq_reg [1:NW];
    logic [CW-2:0] rem_reg [1:NW-1];
    logic [CW-1:0] den_reg [1:NW-1];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [NW-1:0] nq_in;
        logic [CW-2:0] rem_in;
        logic [CW-1:0] den_in;
        logic [CW-1:0] rs;
        logic          ge;
        logic [CW-1:0] diff;

        if (k == 0)
        begin : g_first
            assign nq_in  = num;
            assign rem_in = '0;
            assign den_in = den;
        end
        else
        begin : g_next
            assign nq_in  = nq_reg[k];
            assign rem_in = rem_reg[k];
            assign den_in = den_reg[k];
        end

        assign rs   = {rem_in, nq_in[NW-1]};
        assign ge   = (rs >= den_in);
        assign diff = rs - den_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[k+1] <= {nq_in[NW-2:0], ge};
            end
        end

        // the last stage only needs the quotient
        if (k < NW-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? diff[CW-2:0] : rs[CW-2:0];
                    den_reg[k+1] <= den_in;
                end
            end
        end
    end

    assign quo = nq_reg[NW];

endmodule

// ----- rtl/rbst_merge.sv -----
module rbst_merge #(
    parameter int CW = 32,
    parameter int NW = 49
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    valid_in,
    input  logic [rbst_pkg::NUM_AXES-1:0][NW-1:0]   q_enter,
    input  logic [rbst_pkg::NUM_AXES-1:0][NW-1:0]   q_exit,
    input  rbst_pkg::rbst_side_t                    side,
    output logic                                    valid_reg,
    output logic                                    hit_reg,
    output logic [CW-1:0]                           t_enter_reg,
    output logic [CW-1:0]                           t_exit_reg
);
    import rbst_pkg::*;

    localparam logic [NW-1:0] SLIM = NW'(1) << (CW - 1);
    localparam logic [NW-1:0] SMAXQ = SLIM - NW'(1);
    localparam logic [CW-1:0] SMIN = CW'(1) << (CW - 1);
    localparam logic [CW-1:0] SMAX = ~SMIN;

    function automatic logic [CW-1:0] sat_q(input logic [NW-1:0] q, input logic neg);
        logic [CW-1:0] m;
        begin
            if (neg)
            begin
                m = (q > SLIM) ? SMIN : CW'(-q);
            end
            else
            begin
                m = (q > SMAXQ) ? SMAX : q[CW-1:0];
            end
            return m;
        end
    endfunction

    // stage one: saturate and sign, parallel axes put no limit
    logic                            v1_reg;
    logic                            excl1_reg;
    logic [NUM_AXES-1:0][CW-1:0]     e1_reg;
    logic [NUM_AXES-1:0][CW-1:0]     x1_reg;
    logic [NUM_AXES-1:0][CW-1:0]     e1_next;
    logic [NUM_AXES-1:0][CW-1:0]     x1_next;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            e1_next[a] = side.par[a] ? SMIN : sat_q(q_enter[a], side.neg_enter[a]);
            x1_next[a] = side.par[a] ? SMAX : sat_q(q_exit[a], side.neg_exit[a]);
        end
    end

    // stage two: largest entry and smallest exit
    logic            v2_reg;
    logic            excl2_reg;
    logic [CW-1:0]   e2_reg;
    logic [CW-1:0]   x2_reg;
    logic [CW-1:0]   e2_next;
    logic [CW-1:0]   x2_next;

    always_comb
    begin
        e2_next = e1_reg[0];
        x2_next = x1_reg[0];
        for (int a = 1; a < NUM_AXES; a++)
        begin
            if ($signed(e1_reg[a]) > $signed(e2_next))
            begin
                e2_next = e1_reg[a];
            end
            if ($signed(x1_reg[a]) < $signed(x2_next))
            begin
                x2_next = x1_reg[a];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= valid_in;
            v2_reg    <= v1_reg;
            valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            excl1_reg   <= side.excl;
            e1_reg      <= e1_next;
            x1_reg      <= x1_next;
            excl2_reg   <= excl1_reg;
            e2_reg      <= e2_next;
            x2_reg      <= x2_next;
            hit_reg     <= !excl2_reg && ($signed(e2_reg) <= $signed(x2_reg));
            t_enter_reg <= e2_reg;
            t_exit_reg  <= x2_reg;
        end
    end

endmodule

// ----- rtl/ray_box_slab_test.sv -----
// channel | direction | fields (tdata from bit 0 up)
// --------+-----------+--------------------------------------------------------
// s_axis  | in        | box_lo_x/y/z, box_hi_x/y/z, origin_x/y/z, dir_x/y/z
// m_axis  | out       | hit, t_enter, t_exit
//
// a beat passes the prep registers, the divider stages and the merge stages;
// the restoring dividers produce one quotient bit per stage (six run side by side)
// one beat is accepted every cycle while the output side keeps up
// the whole pipeline holds as one when a finished beat waits at the output
// rst_n clears only the valid bits; payload registers are not reset
module ray_box_slab_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // hit, t_enter, t_exit, zero fill
    output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0]        m_axis_tdata
);
    import rbst_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int NW    = COORD_WIDTH + FRAC_BITS + 1;
    localparam int OUT_W = ((2*COORD_WIDTH+1+7)/8)*8;

    // whole pipeline moves when the output slot is free or being taken
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [NUM_AXES-1:0][CW-1:0] lo;
    logic [NUM_AXES-1:0][CW-1:0] hi;
    logic [NUM_AXES-1:0][CW-1:0] org;
    logic [NUM_AXES-1:0][CW-1:0] dir;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_unpack
        assign lo[a]  = s_axis_tdata[(a)*CW +: CW];
        assign hi[a]  = s_axis_tdata[(3+a)*CW +: CW];
        assign org[a] = s_axis_tdata[(6+a)*CW +: CW];
        assign dir[a] = s_axis_tdata[(9+a)*CW +: CW];
    end

    logic                        prep_valid;
    logic [NUM_AXES-1:0][NW-1:0] num_enter;
    logic [NUM_AXES-1:0][NW-1:0] num_exit;
    logic [NUM_AXES-1:0][CW-1:0] den;
    rbst_side_t                  prep_side;

    rbst_prep #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) u_prep (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .valid_in(s_axis_tvalid),
        .lo(lo),
        .hi(hi),
        .org(org),
        .dir(dir),
        .valid_reg(prep_valid),
        .num_enter_reg(num_enter),
        .num_exit_reg(num_exit),
        .den_reg(den),
        .side_reg(prep_side)
    );

    // six dividers: entry and exit parameter for each axis
    logic [NUM_AXES-1:0][NW-1:0] q_enter;
    logic [NUM_AXES-1:0][NW-1:0] q_exit;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_div
        rbst_div #(.CW(CW), .NW(NW)) u_div_enter (
            .clk(clk), .en(en), .num(num_enter[a]), .den(den[a]), .quo(q_enter[a])
        );
        rbst_div #(.CW(CW), .NW(NW)) u_div_exit (
            .clk(clk), .en(en), .num(num_exit[a]), .den(den[a]), .quo(q_exit[a])
        );
    end

    // valid bits and sideband follow the divider stages
    logic       vpipe_reg [1:NW];
    rbst_side_t spipe_reg [1:NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NW; k++)
            begin
                vpipe_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vpipe_reg[1] <= prep_valid;
            for (int k = 2; k <= NW; k++)
            begin
                vpipe_reg[k] <= vpipe_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spipe_reg[1] <= prep_side;
            for (int k = 2; k <= NW; k++)
            begin
                spipe_reg[k] <= spipe_reg[k-1];
            end
        end
    end

    logic          hit;
    logic [CW-1:0] t_enter;
    logic [CW-1:0] t_exit;

    rbst_merge #(.CW(CW), .NW(NW)) u_merge (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .valid_in(vpipe_reg[NW]),
        .q_enter(q_enter),
        .q_exit(q_exit),
        .side(spipe_reg[NW]),
        .valid_reg(m_axis_tvalid),
        .hit_reg(hit),
        .t_enter_reg(t_enter),
        .t_exit_reg(t_exit)
    );

    assign m_axis_tdata = OUT_W'({t_exit, t_enter, hit});

endmodule

// ----- rtl/rbst_check.sv -----
module rbst_check #(
    parameter int COORD_WIDTH = 32
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_axis_tready,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [((2*COORD_WIDTH+1+7)/8)*8-1:0]   m_axis_tdata
);

    localparam int CW = COORD_WIDTH;

    // an empty output slot never holds the input back
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a waiting result blocks the input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // a hit always has an entry no later than the exit
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |->
        ($signed(m_axis_tdata[CW:1]) <= $signed(m_axis_tdata[2*CW:CW+1])))
        else $error("hit with entry past exit");

    // stalled result beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind ray_box_slab_test rbst_check #(.COORD_WIDTH(COORD_WIDTH)) u_rbst_check (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
